// File: rtl/i2cbb_pkg.sv
// ----------------------------------------------------------------------------
// i2cbb_pkg: shared types for the I2C bit-bang master core
// Command codes, beat payload structs and the engine state record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbb_pkg;

  // Command codes carried in the opcode field.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Phase landmarks of the write and read sequences.
  localparam logic [4:0] PH_WR_ACK_REL  = 5'd16;
  localparam logic [4:0] PH_RD_LAST_BIT = 5'd16;
  localparam logic [4:0] PH_RD_NACK     = 5'd17;
  localparam logic [4:0] PH_RD_LAST     = 5'd18;

  // One timing tick as it arrives.
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_byte;
    logic       sda_line;
  } in_t;

  // Bus levels and status for one tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       ack_missing;
    logic [7:0] read_byte;
  } out_t;

  // Engine state carried from tick to tick.
  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] phase;
    logic [7:0] shift;
    logic [7:0] received;
    logic       ack;
    logic       scl;
    logic       sda;
  } st_t;

endpackage

`default_nettype wire

// File: rtl/i2cbb_phase.sv
// ----------------------------------------------------------------------------
// i2cbb_phase: one tick of the I2C byte engine
// Takes the current engine state and one tick, and gives the bus levels and
// status for that tick together with the state for the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_phase (
  input  i2cbb_pkg::st_t  st_i,
  input  i2cbb_pkg::in_t  item_i,
  output i2cbb_pkg::st_t  st_o,
  output i2cbb_pkg::out_t res_o
);
  import i2cbb_pkg::*;

  cmd_e       cmd_l;
  logic [4:0] phase_l;
  logic [7:0] shift_l;
  logic       busy;
  logic       done;
  logic       scl_a;
  logic       sda_a;
  logic [7:0] shift_a;
  logic       ack_a;
  logic [7:0] rcv_a;
  logic       scl_n;
  logic       sda_n;

  // An idle engine launches a valid command on this same tick.
  always_comb begin
    cmd_l   = st_i.cmd;
    phase_l = st_i.phase;
    shift_l = st_i.shift;
    if (st_i.cmd == CMD_NONE && item_i.opcode >= CMD_START &&
        item_i.opcode <= CMD_READ) begin
      cmd_l   = cmd_e'(item_i.opcode);
      phase_l = '0;
      if (item_i.opcode == CMD_WRITE) begin
        shift_l = item_i.write_byte;
      end else if (item_i.opcode == CMD_READ) begin
        shift_l = '0;
      end
    end
  end

  assign busy = (cmd_l != CMD_NONE);

  // Levels driven during this phase, plus sampling of ACK and read bits.
  always_comb begin
    scl_a   = st_i.scl;
    sda_a   = st_i.sda;
    done    = 1'b0;
    shift_a = shift_l;
    ack_a   = st_i.ack;
    rcv_a   = st_i.received;
    case (cmd_l)
      CMD_START: begin
        if (phase_l == '0) begin
          scl_a = 1'b1;
          sda_a = 1'b1;
        end else begin
          sda_a = 1'b0;
          done  = 1'b1;
        end
      end
      CMD_STOP: begin
        if (phase_l == '0) begin
          sda_a = 1'b0;
        end else begin
          scl_a = 1'b1;
          done  = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (!phase_l[4]) begin
          // Even phase sets the data bit, odd phase raises SCL.
          if (!phase_l[0]) begin
            sda_a = shift_l[3'd7 - phase_l[3:1]];
          end else begin
            scl_a = 1'b1;
          end
        end else if (phase_l == PH_WR_ACK_REL) begin
          sda_a = 1'b1;
        end else begin
          scl_a = 1'b1;
          ack_a = item_i.sda_line;
          done  = 1'b1;
        end
      end
      CMD_READ: begin
        if (phase_l == '0) begin
          sda_a = 1'b1;
        end else if (phase_l <= PH_RD_LAST_BIT) begin
          if (phase_l[0]) begin
            scl_a   = 1'b1;
            shift_a = {shift_l[6:0], item_i.sda_line};
          end
        end else if (phase_l == PH_RD_NACK) begin
          sda_a = 1'b1;
        end else begin
          scl_a = 1'b1;
          rcv_a = shift_l;
          done  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result of this tick.
  always_comb begin
    res_o.scl_level   = scl_a;
    res_o.sda_level   = sda_a;
    res_o.busy_res    = busy;
    res_o.done_res    = done;
    res_o.ack_missing = ack_a;
    res_o.read_byte   = rcv_a;
  end

  // Levels left on the bus after the tick, and the phase advance.
  always_comb begin
    scl_n = scl_a;
    sda_n = sda_a;
    case (cmd_l)
      CMD_START: begin
        if (phase_l == 5'd1) scl_n = 1'b0;
      end
      CMD_STOP: begin
        if (phase_l == 5'd1) sda_n = 1'b1;
      end
      CMD_WRITE: begin
        if (phase_l[0]) scl_n = 1'b0;
      end
      CMD_READ: begin
        if ((phase_l[0] && phase_l <= PH_RD_LAST_BIT) || phase_l == PH_RD_LAST) begin
          scl_n = 1'b0;
        end
      end
      default: begin
      end
    endcase

    st_o.shift    = shift_a;
    st_o.received = rcv_a;
    st_o.ack      = ack_a;
    st_o.scl      = scl_n;
    st_o.sda      = sda_n;
    st_o.cmd      = cmd_l;
    st_o.phase    = phase_l;
    if (busy) begin
      if (done) begin
        st_o.cmd   = CMD_NONE;
        st_o.phase = '0;
      end else begin
        st_o.phase = phase_l + 5'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2c_bitbang_master_core.sv
// ----------------------------------------------------------------------------
// i2c_bitbang_master_core: I2C master byte engine, one bus tick per beat
// Start, stop, write byte and read byte sequences driven tick by tick.
// ----------------------------------------------------------------------------
// Each input beat is one bus timing tick and yields exactly one output beat
// with the SCL and SDA levels for that tick, busy, done, the last ACK status
// and the last byte read. A beat is captured in an input register and then
// decoded against the engine state in a single pass of phase logic into the
// output register, so the block takes one tick per cycle while the output is
// not stalled; the phase decode of one tick is the only step between the two
// registers. A command is taken only while idle: start lasts 2 ticks, stop 2,
// write 18 and read 19.
`default_nettype none

module i2c_bitbang_master_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2cbb_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2cbb_pkg::out_t   out_data_o
);
  import i2cbb_pkg::*;

  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q;
  st_t  st_q;
  st_t  st_d;
  out_t res_d;
  logic advance;
  logic in_take;

  // The held tick moves on when the output register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  i2cbb_phase u_phase (
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_data_i;
  end

  // Engine state, updated once per processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.cmd      <= CMD_NONE;
      st_q.phase    <= '0;
      st_q.shift    <= '0;
      st_q.received <= '0;
      st_q.ack      <= 1'b0;
      st_q.scl      <= 1'b1;
      st_q.sda      <= 1'b1;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A finishing tick always reports busy.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.done_res |-> out_q.busy_res)
    else $error("done reported without busy");

  // The engine is idle after a finishing tick.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.done_res |=> st_q.cmd == CMD_NONE && st_q.phase == '0)
    else $error("engine not idle after done");

  // The phase counter never passes the last read phase.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase <= PH_RD_LAST)
    else $error("phase counter out of range");

  // An idle engine sits at phase zero.
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cmd == CMD_NONE |-> st_q.phase == '0)
    else $error("idle engine with nonzero phase");

  // State only changes when a tick is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("state changed without a processed tick");
`endif

endmodule

`default_nettype wire

// File: tb/i2cbb_tick_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2cbb_tick_checker: bus tick predictor and output beat checker
// Watches both channels of the I2C bit-bang master core. It predicts the bus
// levels and status of every accepted tick and compares them with the output
// beats in order.
// ----------------------------------------------------------------------------

module i2cbb_tick_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  i2cbb_pkg::in_t    in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  i2cbb_pkg::out_t   out_data_i,
  output int unsigned       ticks_pending_o,
  output int unsigned       mismatches_o
);
  import i2cbb_pkg::*;

  // Predicted engine state.
  cmd_e       bus_cmd;
  logic [4:0] bus_phase;
  logic [7:0] bus_shift;
  logic [7:0] bus_received;
  logic       bus_ack;
  logic       bus_scl;
  logic       bus_sda;

  // Predicted output beats, oldest first.
  out_t        expected_ticks[$];
  int unsigned pending_count;
  int unsigned mismatch_count;

  assign ticks_pending_o = pending_count;
  assign mismatches_o    = mismatch_count;

  // Run one bus tick through the engine and queue the output beat it yields.
  task automatic predict_tick(input in_t beat);
    logic [4:0] ph;
    logic       busy;
    logic       done;
    out_t       want;
    // An idle engine takes a known command and runs its first phase at once.
    if (bus_cmd == CMD_NONE && beat.opcode >= CMD_START && beat.opcode <= CMD_READ) begin
      bus_cmd   = cmd_e'(beat.opcode);
      bus_phase = '0;
      if (beat.opcode == CMD_WRITE) bus_shift = beat.write_byte;
      if (beat.opcode == CMD_READ) bus_shift = '0;
    end
    ph   = bus_phase;
    busy = (bus_cmd != CMD_NONE);
    done = 1'b0;

    // Levels driven during this tick.
    case (bus_cmd)
      CMD_START: begin
        if (ph == 5'd0) begin
          bus_scl = 1'b1;
          bus_sda = 1'b1;
        end else begin
          bus_sda = 1'b0;
          done    = 1'b1;
        end
      end
      CMD_STOP: begin
        if (ph == 5'd0) begin
          bus_sda = 1'b0;
        end else begin
          bus_scl = 1'b1;
          done    = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (!ph[4]) begin
          // Even phases set the data bit, odd phases raise the clock.
          if (!ph[0]) bus_sda = bus_shift[3'd7 - ph[3:1]];
          else bus_scl = 1'b1;
        end else if (ph == PH_WR_ACK_REL) begin
          bus_sda = 1'b1;
        end else begin
          bus_scl = 1'b1;
          bus_ack = beat.sda_line;
          done    = 1'b1;
        end
      end
      CMD_READ: begin
        if (ph == 5'd0) begin
          bus_sda = 1'b1;
        end else if (ph <= PH_RD_LAST_BIT) begin
          if (ph[0]) begin
            bus_scl   = 1'b1;
            bus_shift = {bus_shift[6:0], beat.sda_line};
          end
        end else if (ph == PH_RD_NACK) begin
          bus_sda = 1'b1;
        end else begin
          bus_scl      = 1'b1;
          bus_received = bus_shift;
          done         = 1'b1;
        end
      end
      default: ;
    endcase

    want.scl_level   = bus_scl;
    want.sda_level   = bus_sda;
    want.busy_res    = busy;
    want.done_res    = done;
    want.ack_missing = bus_ack;
    want.read_byte   = bus_received;
    expected_ticks.push_back(want);

    // Levels left on the bus once the tick is over.
    case (bus_cmd)
      CMD_START: if (ph == 5'd1) bus_scl = 1'b0;
      CMD_STOP:  if (ph == 5'd1) bus_sda = 1'b1;
      CMD_WRITE: if (ph[0]) bus_scl = 1'b0;
      CMD_READ: begin
        if ((ph[0] && ph <= PH_RD_LAST_BIT) || ph == PH_RD_LAST) bus_scl = 1'b0;
      end
      default: ;
    endcase

    if (busy) begin
      if (done) begin
        bus_cmd   = CMD_NONE;
        bus_phase = '0;
      end else begin
        bus_phase = bus_phase + 5'd1;
      end
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare one output beat with the oldest prediction.
  task automatic compare_tick(input out_t got);
    out_t want;
    if (expected_ticks.size() == 0) begin
      $error("output beat %h arrived with no tick outstanding", got);
      mismatch_count++;
    end else begin
      want = expected_ticks.pop_front();
      check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
      check_field("read_byte", want.read_byte, got.read_byte);
    end
  endtask

  // Both channels are sampled at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_cmd        = CMD_NONE;
      bus_phase      = '0;
      bus_shift      = '0;
      bus_received   = '0;
      bus_ack        = 1'b0;
      bus_scl        = 1'b1;
      bus_sda        = 1'b1;
      mismatch_count = 0;
      expected_ticks.delete();
      pending_count  = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_tick(in_data_i);
      if (out_valid_i && !out_stall_i) compare_tick(out_data_i);
      pending_count = expected_ticks.size();
    end
  end

endmodule

// File: tb/i2c_bitbang_master_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_bitbang_master_core_test: testbench top for the I2C bit-bang master core
// Drives start, stop, write and read sequences tick by tick with random gaps
// and output stalls. A checker beside the core predicts every output beat.
// ----------------------------------------------------------------------------

module i2c_bitbang_master_core_test;
  import i2cbb_pkg::*;

  localparam int TICK_TARGET    = 1250;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  int unsigned ticks_pending;
  int unsigned mismatches;

  int sent_ticks;
  int sender_steady_left;
  int holdoffs_asked;
  int holdoffs_done;

  i2c_bitbang_master_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  i2cbb_tick_checker u_tick_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .ticks_pending_o (ticks_pending),
    .mismatches_o    (mismatches)
  );

  // Clock and a single reset at the start.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one tick and wait for its beat to be taken. Entered and left at a
  // falling edge.
  task automatic send_tick(input in_t tick);
    int gap;
    if (sender_steady_left > 0) begin
      sender_steady_left--;
      gap = 0;
    end else begin
      gap = draw_gap();
      if ($urandom_range(0, 39) == 0) sender_steady_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_data_i.opcode     <= 3'($urandom);
      in_data_i.write_byte <= 8'($urandom);
      in_data_i.sda_line   <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    do @(posedge clk_i); while (in_stall_o);
    sent_ticks++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted beat has come out.
  task automatic await_results();
    in_valid_i <= 1'b0;
    wait (ticks_pending == 0);
    @(negedge clk_i);
  endtask

  task automatic send_idle(input logic [2:0] op);
    in_t tick;
    tick.opcode     = op;
    tick.write_byte = 8'($urandom);
    tick.sda_line   = 1'($urandom);
    send_tick(tick);
  endtask

  // Issue one command on an idle engine and fill its remaining phases with
  // random ticks, whose opcodes the busy engine must ignore. The slave drives
  // bus_bits on the read sample phases and ack_level on the write ACK phase.
  task automatic run_command(input cmd_e op, input logic [7:0] wb,
                             input logic [7:0] bus_bits, input logic ack_level);
    int   len;
    in_t  tick;
    case (op)
      CMD_START, CMD_STOP: len = 2;
      CMD_WRITE:           len = 18;
      CMD_READ:            len = 19;
      default:             len = 1;
    endcase
    for (int k = 0; k < len; k++) begin
      tick.opcode     = (k == 0) ? op : 3'($urandom);
      tick.write_byte = (k == 0) ? wb : 8'($urandom);
      tick.sda_line   = 1'($urandom);
      if (op == CMD_READ && k % 2 == 1 && k <= 15) tick.sda_line = bus_bits[7 - k / 2];
      if (op == CMD_WRITE && k == 17) tick.sda_line = ack_level;
      send_tick(tick);
    end
  endtask

  // A framed transfer: start, a few bytes, stop; sometimes with a frame edge
  // missing or stray ticks between the commands.
  task automatic random_transfer();
    int bytes;
    if ($urandom_range(0, 9) != 0) run_command(CMD_START, 8'($urandom), 8'h00, 1'b0);
    bytes = $urandom_range(1, 3);
    repeat (bytes) begin
      if ($urandom_range(0, 4) == 0) send_idle(3'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 1) begin
        run_command(CMD_WRITE, 8'($urandom), 8'h00, $urandom_range(0, 3) == 0);
      end else begin
        run_command(CMD_READ, 8'($urandom), 8'($urandom), 1'b0);
      end
    end
    if ($urandom_range(0, 9) != 0) run_command(CMD_STOP, 8'($urandom), 8'h00, 1'b0);
  endtask

  // Stimulus and verdict.
  initial begin
    bit asked_holdoff;
    bit paused_once;
    in_valid_i         = 1'b0;
    in_data_i          = '0;
    sent_ticks         = 0;
    sender_steady_left = 0;
    holdoffs_asked     = 0;
    asked_holdoff      = 1'b0;
    paused_once        = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);

    // Directed: idle and unknown opcodes, then each command at its extremes.
    send_idle(CMD_NONE);
    send_idle(3'd5);
    send_idle(3'd6);
    send_idle(3'd7);
    run_command(CMD_STOP, 8'h00, 8'h00, 1'b0);
    run_command(CMD_START, 8'hFF, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 8'h00, 1'b1);
    run_command(CMD_WRITE, 8'h00, 8'h00, 1'b0);
    run_command(CMD_READ, 8'h00, 8'hFF, 1'b0);
    run_command(CMD_READ, 8'hFF, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hA5, 8'h00, 1'b1);
    run_command(CMD_READ, 8'h00, 8'h5A, 1'b0);
    run_command(CMD_STOP, 8'hFF, 8'h00, 1'b0);
    send_idle(CMD_NONE);

    // Random: mostly framed transfers, the rest raw noise.
    while (sent_ticks < TICK_TARGET) begin
      if (!asked_holdoff && sent_ticks >= 400) begin
        asked_holdoff = 1'b1;
        holdoffs_asked++;
      end
      if (!paused_once && sent_ticks >= 800) begin
        paused_once = 1'b1;
        await_results();
      end
      if ($urandom_range(0, 6) != 0) begin
        random_transfer();
      end else begin
        repeat ($urandom_range(1, 6)) send_idle(3'($urandom_range(0, 7)));
      end
    end

    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && ticks_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output side: random stall runs, steady stretches and one long hold-off.
  initial begin
    int stall_left;
    int free_left;
    out_stall_i   = 1'b0;
    holdoffs_done = 0;
    stall_left    = 0;
    free_left     = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (holdoffs_done < holdoffs_asked) begin
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk_i);
        holdoffs_done++;
      end
      if (stall_left == 0 && free_left == 0) begin
        stall_left = draw_gap();
        free_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        free_left--;
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
